/* sv/fir_filter_direct_form_core_assert.svh */
// Assertion macros for the FIR filter RTL.
`ifndef FIR_FILTER_DIRECT_FORM_CORE_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_CORE_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define FIRDF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion on the block clock and reset.
`define FIRDF_ASSERT(label, prop, msg) \
  `FIRDF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* sv/firdf_pkg.sv */
// Shared types and constants of the FIR filter.
package firdf_pkg;

  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 6;
  localparam int TAP_COUNT_W = 7;
  localparam int MODE_W      = 2;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILTER = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

/* sv/fir_filter_direct_form_core.sv */
// Top level of the direct-form FIR filter: control, tap cell chain and output register.
//
// Input items arrive on the s_axis channel; tuser carries the mode (filter, load, clear).
// A filter item shifts its sample into the tap chain and yields one result on m_axis:
// the scaled, saturated sum in tdata and the saturation flag in tuser.
// Load and clear items give no result; mode 3 is dropped.
// Each cell holds one delay slot and one coefficient; a partial sum walks the chain one
// cell per cycle; a filter result enters the output register once the run counter reaches
// its end, and no new item is taken while a filter item is in the chain. tap_count is
// written through cfg_we_i / cfg_data_i; the user must write it only while the block is
// idle; the block does not enforce this. Zero acts as one tap, values above TAPS as TAPS.
// Reset clears the delay line and coefficients and sets tap_count to 64.
// A result waits in the output register while m_axis_tready is low; load and clear items
// are still taken meanwhile, and a following filter result holds in the chain until the
// output register is free.
module fir_filter_direct_form_core #(
  parameter int TAPS           = 64,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [firdf_pkg::TAP_COUNT_W-1:0]        cfg_data_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // sample, coef_index, coef_value (from bit 0 up), zero padded to bytes
  input  logic [((SAMPLE_BITS + firdf_pkg::COEF_IDX_W + firdf_pkg::COEF_W + 7) / 8) * 8 - 1:0]
                                                   s_axis_tdata,
  // mode
  input  logic [firdf_pkg::MODE_W-1:0]             s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // filtered, zero padded to bytes
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // saturated
  output logic                                     m_axis_tuser
);
  import firdf_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ACC_W = SAMPLE_BITS + COEF_W + $clog2(TAPS) + 1;
  localparam int CNT_W = $clog2(TAPS + 2);
  localparam logic [CNT_W-1:0] DONE = CNT_W'(TAPS + 1);

  mode_e                    mode;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [COEF_IDX_W-1:0]    coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic                     in_acc;
  logic                     load;
  cell_ctrl_t               ctrl;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]   out_data_q;
  logic                     out_sat_q;
  logic [TAP_COUNT_W-1:0]   tap_count_q;
  logic                     out_free;
  logic                     out_load;
  logic                     blocked;

  logic [SAMPLE_BITS-1:0]   sat_y;
  logic                     sat_flag;

  logic signed [SAMPLE_BITS-1:0] sample_chain [TAPS+1];
  logic signed [ACC_W-1:0]       sum_chain    [TAPS+1];

  assign mode       = mode_e'(s_axis_tuser);
  assign in_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign coef_index = s_axis_tdata[SAMPLE_BITS +: COEF_IDX_W];
  assign coef_value = s_axis_tdata[SAMPLE_BITS + COEF_IDX_W +: COEF_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl = '0;
    load = 1'b0;
    unique case (mode)
      MODE_FILTER: ctrl.shift = in_acc;
      MODE_LOAD:   load       = in_acc && (int'(coef_index) < TAPS);
      MODE_CLEAR:  ctrl.clear = in_acc;
      default: ;
    endcase
  end

  assign sample_chain[0] = in_sample;
  assign sum_chain[0]    = '0;

  for (genvar K = 0; K < TAPS; K++) begin : g_cell
    logic active;
    logic coef_we;

    assign active  = (K == 0) || (int'(tap_count_q) > K);
    assign coef_we = load && (int'(coef_index) == K);

    firdf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ACC_W      (ACC_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .coef_we_i(coef_we),
      .coef_i   (coef_value),
      .active_i (active),
      .sample_i (sample_chain[K]),
      .sample_o (sample_chain[K+1]),
      .sum_i    (sum_chain[K]),
      .sum_o    (sum_chain[K+1])
    );
  end

  firdf_sat #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .ACC_W         (ACC_W),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_sat (
    .sum_i(sum_chain[TAPS]),
    .y_o  (sat_y),
    .sat_o(sat_flag)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign blocked  = (state_q == S_RUN) && (cnt_q == DONE) && !out_free;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (ctrl.shift) begin
          state_d = S_RUN;
          cnt_d   = '0;
        end
      end
      S_RUN: begin
        if (cnt_q != DONE) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      tap_count_q <= TAP_COUNT_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= sat_y;
      out_sat_q  <= sat_flag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);
  assign m_axis_tuser  = out_sat_q;

`include "fir_filter_direct_form_core_assert.svh"

  `FIRDF_ASSERT(a_rose_after_run, $rose(m_axis_tvalid) |-> $past(state_q == S_RUN), "stray result")
  `FIRDF_ASSERT(a_filter_starts_run, ctrl.shift |=> state_q == S_RUN && cnt_q == '0, "no start")
  `FIRDF_ASSERT(a_cnt_bound, (state_q == S_RUN) |-> (cnt_q <= DONE), "run counter overflow")
  `FIRDF_ASSERT(a_hold_when_blocked, blocked |=> state_q == S_RUN && out_valid_q, "result lost")

endmodule

/* sv/firdf_cell.sv */
// One tap cell: delay slot, coefficient, product register and partial-sum stage.
module firdf_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  firdf_pkg::cell_ctrl_t               ctrl_i,
  input  logic                                coef_we_i,
  input  logic signed [firdf_pkg::COEF_W-1:0] coef_i,
  input  logic                                active_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_o,
  input  logic signed [ACC_W-1:0]             sum_i,
  output logic signed [ACC_W-1:0]             sum_o
);
  import firdf_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [COEF_W-1:0]      coef_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       sum_q;
  logic signed [ACC_W-1:0]       term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coef_q   <= '0;
    end else begin
      if (ctrl_i.clear) begin
        sample_q <= '0;
      end else if (ctrl_i.shift) begin
        sample_q <= sample_i;
      end
      if (coef_we_i) begin
        coef_q <= coef_i;
      end
    end
  end

  assign term = active_i ? {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} : '0;

  always_ff @(posedge clk_i) begin
    prod_q <= coef_q * sample_q;
    sum_q  <= sum_i + term;
  end

  assign sample_o = sample_q;
  assign sum_o    = sum_q;

endmodule

/* sv/firdf_sat.sv */
// Output scaling: arithmetic right shift and saturation to the sample width.
module firdf_sat #(
  parameter int SAMPLE_BITS    = 16,
  parameter int ACC_W          = 40,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic signed [ACC_W-1:0]       sum_i,
  output logic        [SAMPLE_BITS-1:0] y_o,
  output logic                          sat_o
);
  import firdf_pkg::*;

  localparam logic signed [ACC_W-1:0] HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] LO = -HI - ACC_W'(1);

  logic signed [ACC_W-1:0] scaled;

  assign scaled = sum_i >>> COEF_FRAC_BITS;

  always_comb begin
    if (scaled > HI) begin
      y_o   = HI[SAMPLE_BITS-1:0];
      sat_o = 1'b1;
    end else if (scaled < LO) begin
      y_o   = LO[SAMPLE_BITS-1:0];
      sat_o = 1'b1;
    end else begin
      y_o   = scaled[SAMPLE_BITS-1:0];
      sat_o = 1'b0;
    end
  end

endmodule

/* tb/sv/fir_filter_direct_form_checker.sv */
// Checker for the FIR filter core: tracks filter state, predicts each result and compares it.
module fir_filter_direct_form_checker #(
  parameter int TAPS           = 64,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 15,
  parameter int IN_W           = 40,
  parameter int OUT_W          = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [firdf_pkg::TAP_COUNT_W-1:0] cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,
  input  logic [firdf_pkg::MODE_W-1:0]      s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [OUT_W-1:0]                  m_axis_tdata,
  input  logic                              m_axis_tuser,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                clipped_o
);
  import firdf_pkg::*;

  localparam longint OUT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } fir_result_t;

  logic signed [SAMPLE_BITS-1:0] history [TAPS];
  logic signed [COEF_W-1:0]      coef_store [TAPS];
  int                            newest_slot;
  logic [TAP_COUNT_W-1:0]        tap_setting;
  fir_result_t                   expected_q [$];

  task automatic apply_item(input logic [MODE_W-1:0] mode, input logic [IN_W-1:0] data);
    longint      acc;
    longint      scaled;
    int          active;
    int          slot;
    fir_result_t res;
    case (mode)
      MODE_LOAD: begin
        if (data[SAMPLE_BITS +: COEF_IDX_W] < TAPS)
          coef_store[data[SAMPLE_BITS +: COEF_IDX_W]] = data[SAMPLE_BITS + COEF_IDX_W +: COEF_W];
      end
      MODE_CLEAR: begin
        for (int i = 0; i < TAPS; i++) history[i] = '0;
        newest_slot = 0;
      end
      MODE_FILTER: begin
        newest_slot = (newest_slot + 1) % TAPS;
        history[newest_slot] = data[SAMPLE_BITS-1:0];
        active = (tap_setting == 0) ? 1 : ((tap_setting > TAPS) ? TAPS : int'(tap_setting));
        acc = 0;
        slot = newest_slot;
        for (int k = 0; k < active; k++) begin
          acc += longint'(coef_store[k]) * longint'(history[slot]);
          slot = (slot == 0) ? TAPS - 1 : slot - 1;
        end
        scaled = acc >>> COEF_FRAC_BITS;
        res.saturated = 1'b1;
        if (scaled > OUT_MAX) scaled = OUT_MAX;
        else if (scaled < OUT_MIN) scaled = OUT_MIN;
        else res.saturated = 1'b0;
        res.filtered = scaled[SAMPLE_BITS-1:0];
        expected_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic compare_result(input logic signed [SAMPLE_BITS-1:0] got_y, input logic got_sat);
    fir_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result filtered %0d saturated %0d", $time, got_y, got_sat);
      fail_count_o++;
    end else begin
      want = expected_q.pop_front();
      checked_o++;
      if (want.saturated) clipped_o++;
      if (got_y !== want.filtered) begin
        $display("%0t: filtered expected %0d actual %0d", $time, want.filtered, got_y);
        fail_count_o++;
      end
      if (got_sat !== want.saturated) begin
        $display("%0t: saturated expected %0d actual %0d", $time, want.saturated, got_sat);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        history[i]    = '0;
        coef_store[i] = '0;
      end
      newest_slot = 0;
      tap_setting = TAP_COUNT_RST;
      expected_q.delete();
    end else begin
      if (cfg_we_i) tap_setting = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) apply_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata[SAMPLE_BITS-1:0], m_axis_tuser);
    end
    pending_o = expected_q.size();
  end

endmodule

/* tb/sv/fir_filter_direct_form_core_tb.sv */
// Testbench top for the FIR filter core: clock, reset, stimulus, tap settings and verdict.
module fir_filter_direct_form_core_tb;
  import firdf_pkg::*;

  localparam int TAPS           = 64;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int IN_W  = ((SAMPLE_BITS + COEF_IDX_W + COEF_W + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DRAIN_CYCLES   = TAPS + 16;
  localparam int PHASE_ITEMS    = 74;
  localparam int STEADY_PHASE   = 3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [TAP_COUNT_W-1:0] cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata;
  logic                   m_axis_tuser;

  bit idle_off = 1'b0;
  int fails, pending, checked, clipped;
  int n_filter, n_load, n_clear, n_ignored, n_settings;
  int tap_plan [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  fir_filter_direct_form_core #(
    .TAPS          (TAPS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  fir_filter_direct_form_checker #(
    .TAPS          (TAPS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .IN_W          (IN_W),
    .OUT_W         (OUT_W)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= idle_off || ($urandom_range(99) >= 36);
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SAMPLE_BITS-1:0] sample,
                           input logic [COEF_IDX_W-1:0] idx, input logic [COEF_W-1:0] coef);
    while (!idle_off && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({coef, idx, sample});
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    case (mode)
      MODE_FILTER: n_filter++;
      MODE_LOAD:   n_load++;
      MODE_CLEAR:  n_clear++;
      default:     n_ignored++;
    endcase
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_taps(input logic [TAP_COUNT_W-1:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [15:0] pick_value(input int small_span);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h7FFF;
    if (sel == 1) return 16'h8000;
    if (sel < 5) return 16'($urandom_range(2 * small_span - 1)) - 16'(small_span);
    return 16'($urandom());
  endfunction

  task automatic run_random_phase(input int count);
    int done;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(MODE_FILTER, pick_value(128), 6'($urandom()), 16'($urandom()));
        done++;
      end else if (pick < 88) begin
        send_item(MODE_LOAD, 16'($urandom()), 6'($urandom_range(TAPS - 1)), pick_value(1024));
        done++;
      end else if (pick < 94) begin
        send_item(MODE_CLEAR, 16'($urandom()), 6'($urandom()), 16'($urandom()));
        done++;
      end else begin
        send_item(MODE_UNUSED, 16'($urandom()), 6'($urandom()), 16'($urandom()));
      end
    end
  endtask

  initial begin
    tap_plan = '{1, 0, 127, 64, 65, 2, 33, 3};
    tap_plan[7] = $urandom_range(3, TAPS - 1);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(MODE_FILTER, 16'h7FFF, '0, '0);
    send_item(MODE_LOAD, '0, 6'd0, 16'h7FFF);
    send_item(MODE_LOAD, '0, 6'd63, 16'h8000);
    send_item(MODE_LOAD, '0, 6'd1, 16'h8000);
    send_item(MODE_FILTER, 16'h7FFF, '0, '0);
    send_item(MODE_FILTER, 16'h8000, '0, '0);
    send_item(MODE_FILTER, 16'h0000, '0, '0);
    send_item(MODE_FILTER, 16'hFFFF, '0, '0);
    send_item(MODE_FILTER, 16'h0001, '0, '0);
    send_item(MODE_UNUSED, 16'h5A5A, 6'd5, 16'h1234);
    send_item(MODE_CLEAR, 16'hFFFF, 6'h3F, 16'hFFFF);
    send_item(MODE_FILTER, 16'h8000, '0, '0);
    send_item(MODE_LOAD, '0, 6'd1, 16'h7FFF);
    send_item(MODE_LOAD, '0, 6'd2, 16'h7FFF);
    send_item(MODE_LOAD, '0, 6'd3, 16'h7FFF);
    repeat (3) send_item(MODE_FILTER, 16'h7FFF, '0, '0);
    repeat (3) send_item(MODE_FILTER, 16'h8000, '0, '0);
    send_item(MODE_CLEAR, '0, '0, '0);
    send_item(MODE_FILTER, 16'h1234, '0, '0);

    for (int p = 0; p < 8; p++) begin
      program_taps(7'(tap_plan[p]));
      idle_off <= (p == STEADY_PHASE);
      run_random_phase(PHASE_ITEMS);
    end
    idle_off <= 1'b0;
    drain_results();

    $display("Ran %0d filter, %0d load, %0d clear and %0d unused-mode items over %0d tap settings.",
             n_filter, n_load, n_clear, n_ignored, n_settings + 1);
    $display("Compared %0d results, %0d of them clipped.", checked, clipped);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
